[hdl/tjh_pkg.sv]
// Shared widths, op codes and constants of the tick jitter histogram monitor.
`timescale 1ns / 1ps
`default_nettype none
package tjh_pkg;

    // Field widths
    localparam int OP_W     = 1;
    localparam int NOW_W    = 32;
    localparam int CFG_W    = 20;
    localparam int PERIOD_W = 31;
    localparam int P99_W    = 14;
    localparam int COUNT_W  = 32;

    // Op codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b0;
    localparam logic [OP_W-1:0] OP_REPORT = 1'b1;

    // Tick period after reset, in us
    localparam logic [CFG_W-1:0] TICK_PERIOD_RESET = 20'd1000;

    // p99 target = count - floor(count / 100); division by reciprocal
    localparam logic [COUNT_W-1:0] P99_DIV   = 32'd100;
    localparam logic [COUNT_W-1:0] P99_RECIP = 32'd42949672;  // floor(2^32 / 100)

endpackage
`default_nettype wire

[hdl/tjh_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tjh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hdl/tick_jitter_histogram_p99_core.sv]
// Top level of the tick jitter monitor: tick test, period histogram in RAM, p99 report.
// Samples: a sample that fires no tick gives its result in the cycle after it is taken; a
//   ticking sample goes through accept, bin divide, bin address and bin read-modify-write.
// Commands: no new command is taken while busy; a report walks the bin RAM at one bin
//   read per cycle (skipped on an empty window), with busy high until its result.
// Reset: a clearing pass writes zero to all BIN_COUNT bins with busy high; the period
//   register is written at any time. Results are strobed for one cycle, no stall.
`timescale 1ns / 1ps
`default_nettype none
module tick_jitter_histogram_p99_core #(
    parameter int BIN_COUNT    = 101,
    parameter int BIN_WIDTH_US = 100
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [tjh_pkg::CFG_W-1:0]     i_cfg_wdata,
    // Command
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tjh_pkg::OP_W-1:0]      i_op,
    input  wire logic [tjh_pkg::NOW_W-1:0]     i_now_us,
    // Result
    output logic                               o_valid,
    output logic                               o_tick_fired,
    output logic      [tjh_pkg::PERIOD_W-1:0]  o_period_us,
    output logic      [tjh_pkg::PERIOD_W-1:0]  o_window_max_us,
    output logic      [tjh_pkg::P99_W-1:0]     o_window_p99_us
);

    import tjh_pkg::*;

    // Derived sizes
    localparam int IW       = $clog2(BIN_COUNT);
    localparam int CLAMP_US = (BIN_COUNT - 1) * BIN_WIDTH_US;
    localparam int XW       = $clog2(CLAMP_US + 1);
    localparam int CW       = COUNT_W + $clog2(BIN_COUNT) + 1;
    localparam int MW       = 2 * XW + 1;
    localparam int PW       = IW + $clog2(BIN_WIDTH_US + 1) + 1;

    localparam logic [IW-1:0]       LAST_BIN  = IW'(BIN_COUNT - 1);
    localparam logic [PERIOD_W-1:0] CLAMP_P   = PERIOD_W'(CLAMP_US);
    localparam logic [XW:0]         BIN_RECIP = (XW + 1)'((64'd1 << XW) / BIN_WIDTH_US);
    localparam logic [XW-1:0]       BIN_W_X   = XW'(BIN_WIDTH_US);
    localparam logic [P99_W-1:0]    P99_OVF   = P99_W'(BIN_COUNT * BIN_WIDTH_US);

    // Sequencer states
    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SDIV  = 4'd2;
    localparam logic [3:0] ST_SBIN  = 4'd3;
    localparam logic [3:0] ST_SRMW  = 4'd4;
    localparam logic [3:0] ST_RDIV1 = 4'd5;
    localparam logic [3:0] ST_RDIV2 = 4'd6;
    localparam logic [3:0] ST_RPT   = 4'd7;
    localparam logic [3:0] ST_ROUT  = 4'd8;

    // Control registers
    logic [3:0]          r_state,       n_state;
    logic                r_started,     n_started;
    logic [NOW_W-1:0]    r_ref,         n_ref;
    logic [PERIOD_W-1:0] r_max,         n_max;
    logic [COUNT_W-1:0]  r_count,       n_count;
    logic [CFG_W-1:0]    r_tick_period;
    logic [IW-1:0]       r_idx,         n_idx;
    logic                r_issuing,     n_issuing;
    logic                r_rd_vld,      n_rd_vld;
    logic                r_found,       n_found;
    logic                r_out_valid,   n_out_valid;

    // Payload registers
    logic [XW-1:0]       r_x,           n_x;
    logic                r_clamp,       n_clamp;
    logic [IW-1:0]       r_q0,          n_q0;
    logic [IW-1:0]       r_bin,         n_bin;
    logic [PERIOD_W-1:0] r_period,      n_period;
    logic [COUNT_W-1:0]  r_snap_cnt,    n_snap_cnt;
    logic [PERIOD_W-1:0] r_snap_max,    n_snap_max;
    logic [COUNT_W-1:0]  r_q0c,         n_q0c;
    logic [COUNT_W-1:0]  r_target,      n_target;
    logic [CW-1:0]       r_cum,         n_cum;
    logic [IW-1:0]       r_rd_idx,      n_rd_idx;
    logic [IW-1:0]       r_hit,         n_hit;
    logic                r_out_fire,    n_out_fire;
    logic [PERIOD_W-1:0] r_out_period,  n_out_period;
    logic [PERIOD_W-1:0] r_out_max,     n_out_max;
    logic [P99_W-1:0]    r_out_p99,     n_out_p99;

    // Bin RAM port
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [COUNT_W-1:0]  w_wdata;
    logic [IW-1:0]       w_raddr;
    logic [COUNT_W-1:0]  w_rdata;

    // Datapath nets
    logic                w_accept;
    logic [NOW_W-1:0]    w_ref_eff;
    logic [NOW_W-1:0]    w_elapsed;
    logic                w_fire;
    logic [MW-1:0]       w_bprod;
    logic [XW-1:0]       w_brem;
    logic [IW-1:0]       w_bq;
    logic [2*COUNT_W-1:0] w_cprod;
    logic [COUNT_W-1:0]  w_crem;
    logic [COUNT_W-1:0]  w_cq;
    logic [CW-1:0]       w_sum;
    logic [PW-1:0]       w_mid;

    tjh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Tick test on the incoming sample
    assign w_ref_eff = r_started ? r_ref : i_now_us;
    assign w_elapsed = i_now_us - w_ref_eff;
    assign w_fire    = !w_elapsed[NOW_W-1] && (w_elapsed >= NOW_W'(r_tick_period));

    // Bin index: x / BIN_WIDTH_US by reciprocal, then one correction step
    assign w_bprod = MW'(r_x) * MW'(BIN_RECIP);
    assign w_brem  = r_x - XW'(r_q0) * BIN_W_X;
    assign w_bq    = (w_brem >= BIN_W_X) ? (r_q0 + 1'b1) : r_q0;

    // p99 target: count - floor(count / 100)
    assign w_cprod = (2 * COUNT_W)'(r_snap_cnt) * (2 * COUNT_W)'(P99_RECIP);
    assign w_crem  = r_snap_cnt - r_q0c * P99_DIV;
    assign w_cq    = (w_crem >= P99_DIV) ? (r_q0c + 1'b1) : r_q0c;

    // Walk accumulation and bin midpoint
    assign w_sum = r_cum + CW'(w_rdata);
    assign w_mid = PW'(r_hit) * PW'(BIN_WIDTH_US) + PW'(BIN_WIDTH_US / 2);

    // Sequencer and datapath next state
    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_ref        = r_ref;
        n_max        = r_max;
        n_count      = r_count;
        n_idx        = r_idx;
        n_issuing    = r_issuing;
        n_rd_vld     = 1'b0;
        n_found      = r_found;
        n_out_valid  = 1'b0;
        n_x          = r_x;
        n_clamp      = r_clamp;
        n_q0         = r_q0;
        n_bin        = r_bin;
        n_period     = r_period;
        n_snap_cnt   = r_snap_cnt;
        n_snap_max   = r_snap_max;
        n_q0c        = r_q0c;
        n_target     = r_target;
        n_cum        = r_cum;
        n_rd_idx     = r_rd_idx;
        n_hit        = r_hit;
        n_out_fire   = r_out_fire;
        n_out_period = r_out_period;
        n_out_max    = r_out_max;
        n_out_p99    = r_out_p99;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = '0;
        w_raddr      = r_idx;

        unique case (r_state)
            // Clearing pass after reset
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                if (r_idx == LAST_BIN) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_REPORT) begin
                        n_snap_max = r_max;
                        n_snap_cnt = r_count;
                        n_max      = '0;
                        n_count    = '0;
                        if (r_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_fire   = 1'b0;
                            n_out_period = '0;
                            n_out_max    = r_max;
                            n_out_p99    = '0;
                        end else begin
                            n_state = ST_RDIV1;
                        end
                    end else begin
                        n_started = 1'b1;
                        n_ref     = w_fire ? (w_ref_eff + NOW_W'(r_tick_period)) : w_ref_eff;
                        if (w_fire) begin
                            if (w_elapsed[PERIOD_W-1:0] > r_max) begin
                                n_max = w_elapsed[PERIOD_W-1:0];
                            end
                            n_count  = (r_count == '1) ? r_count : (r_count + 1'b1);
                            n_period = w_elapsed[PERIOD_W-1:0];
                            n_x      = w_elapsed[XW-1:0];
                            n_clamp  = (w_elapsed[PERIOD_W-1:0] >= CLAMP_P);
                            n_state  = ST_SDIV;
                        end else begin
                            n_out_valid  = 1'b1;
                            n_out_fire   = 1'b0;
                            n_out_period = '0;
                            n_out_max    = '0;
                            n_out_p99    = '0;
                        end
                    end
                end
            end

            // Sample: quotient estimate
            ST_SDIV: begin
                n_q0    = IW'(w_bprod >> XW);
                n_state = ST_SBIN;
            end

            // Sample: corrected bin, issue bin read
            ST_SBIN: begin
                n_bin   = r_clamp ? LAST_BIN : w_bq;
                w_raddr = r_clamp ? LAST_BIN : w_bq;
                n_state = ST_SRMW;
            end

            // Sample: saturating bin increment and result
            ST_SRMW: begin
                w_we         = 1'b1;
                w_waddr      = r_bin;
                w_wdata      = (w_rdata == '1) ? w_rdata : (w_rdata + 1'b1);
                n_out_valid  = 1'b1;
                n_out_fire   = 1'b1;
                n_out_period = r_period;
                n_out_max    = '0;
                n_out_p99    = '0;
                n_state      = ST_IDLE;
            end

            // Report: target quotient estimate
            ST_RDIV1: begin
                n_q0c   = w_cprod[2*COUNT_W-1:COUNT_W];
                n_state = ST_RDIV2;
            end

            // Report: target, then start the walk
            ST_RDIV2: begin
                n_target  = r_snap_cnt - w_cq;
                n_idx     = '0;
                n_issuing = 1'b1;
                n_cum     = '0;
                n_found   = 1'b0;
                n_state   = ST_RPT;
            end

            // Report: cumulative walk, clearing each bin behind the read
            ST_RPT: begin
                if (r_issuing) begin
                    w_raddr  = r_idx;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    if (r_idx == LAST_BIN) begin
                        n_issuing = 1'b0;
                        n_idx     = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    w_we    = 1'b1;
                    w_waddr = r_rd_idx;
                    if (!r_found) begin
                        n_cum = w_sum;
                        if (w_sum >= CW'(r_target)) begin
                            n_found = 1'b1;
                            n_hit   = r_rd_idx;
                        end
                    end
                    if (r_rd_idx == LAST_BIN) begin
                        n_state = ST_ROUT;
                    end
                end
            end

            // Report: result
            ST_ROUT: begin
                n_out_valid  = 1'b1;
                n_out_fire   = 1'b0;
                n_out_period = '0;
                n_out_max    = r_snap_max;
                n_out_p99    = r_found ? w_mid[P99_W-1:0] : P99_OVF;
                n_state      = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_started   <= 1'b0;
            r_ref       <= '0;
            r_max       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_ref       <= n_ref;
            r_max       <= n_max;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_issuing   <= n_issuing;
            r_rd_vld    <= n_rd_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Tick period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_tick_period <= i_cfg_wdata;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_clamp      <= n_clamp;
        r_q0         <= n_q0;
        r_bin        <= n_bin;
        r_period     <= n_period;
        r_snap_cnt   <= n_snap_cnt;
        r_snap_max   <= n_snap_max;
        r_q0c        <= n_q0c;
        r_target     <= n_target;
        r_cum        <= n_cum;
        r_rd_idx     <= n_rd_idx;
        r_hit        <= n_hit;
        r_out_fire   <= n_out_fire;
        r_out_period <= n_out_period;
        r_out_max    <= n_out_max;
        r_out_p99    <= n_out_p99;
    end

    assign o_valid         = r_out_valid;
    assign o_tick_fired    = r_out_fire;
    assign o_period_us     = r_out_period;
    assign o_window_max_us = r_out_max;
    assign o_window_p99_us = r_out_p99;

endmodule
`default_nettype wire
